// ===== hw/rtl/bfpa_pkg.sv =====
// Package for the best-fit partition allocator.
// Holds field widths, the mode codes and the tag store write request type.
// No dependencies.
`default_nettype none

package bfpa_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned SizeW    = 16;
  localparam int unsigned JobW     = 8;
  localparam int unsigned PartIdxW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MaskW    = 6;

  // Number of size registers that exist, whatever the partition count.
  localparam int unsigned MaxParts = 6;

  // Default number of partitions that are searched and released.
  localparam int unsigned NumPartitionsDefault = 6;

  // Operation carried in the mode field of an input beat.
  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  // Write request from the sequencer to the tag store.
  typedef struct packed {
    logic                en;
    logic [PartIdxW-1:0] addr;
    logic [JobW-1:0]     data;
  } tag_wr_t;

endpackage : bfpa_pkg

`default_nettype wire

// ===== hw/rtl/bfpa_in_if.sv =====
// Input channel of the best-fit partition allocator: one request per beat.
// Depends on bfpa_pkg for the field widths.
`default_nettype none

interface bfpa_in_if
  import bfpa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [JobW-1:0]    job_id;
  logic [SizeW-1:0]   request_size;

  modport source (output valid, mode, job_id, request_size, input ready);
  modport sink   (input valid, mode, job_id, request_size, output ready);
endinterface : bfpa_in_if

`default_nettype wire

// ===== hw/rtl/bfpa_out_if.sv =====
// Result channel of the best-fit partition allocator: one result per beat.
// Depends on bfpa_pkg for the field widths.
`default_nettype none

interface bfpa_out_if
  import bfpa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                success;
  logic [PartIdxW-1:0] partition_index;
  logic [MaskW-1:0]    freed_mask;

  modport source (output valid, success, partition_index, freed_mask, input ready);
  modport sink   (input valid, success, partition_index, freed_mask, output ready);
endinterface : bfpa_out_if

`default_nettype wire

// ===== hw/rtl/bfpa_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// Depends on bfpa_pkg for the field widths.
`default_nettype none

interface bfpa_cfg_if
  import bfpa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [SizeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : bfpa_cfg_if

`default_nettype wire

// ===== hw/rtl/best_fit_partition_allocator_core.sv =====
// Best-fit fixed-partition allocator: owner tags in a synchronous-read memory.
// A request with a nonzero job reads one partition tag per cycle, evaluates
// each tag in the cycle after its read, then loads the result into the output
// register once that register is free. The next request is taken only after
// the previous result has been loaded; job zero is refused without a scan.
// Reset marks every partition free and clears all sizes; no clearing pass.
`default_nettype none

module best_fit_partition_allocator_core
  import bfpa_pkg::*;
#(
  parameter int unsigned NumPartitions = NumPartitionsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfpa_in_if.sink   in_if,
  bfpa_out_if.source out_if,
  bfpa_cfg_if.sink  cfg_if
);

  localparam int unsigned IdxW = (NumPartitions > 1) ? $clog2(NumPartitions) : 1;
  localparam int unsigned CntW = $clog2(NumPartitions + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Partition size registers.
  logic [SizeW-1:0] size_q [MaxParts];

  // Latched request.
  logic             mode_q;
  logic [JobW-1:0]  job_q;
  logic [SizeW-1:0] req_q;

  // Scan counters and pipeline.
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] pidx_q, pidx_d;

  // Best-fit tracking and release mask.
  logic             found_q, found_d;
  logic [IdxW-1:0]  best_q, best_d;
  logic [SizeW-1:0] left_q, left_d;
  logic [MaskW-1:0] mask_q, mask_d;

  // Result waiting for the output register.
  logic                res_succ_q, res_succ_d;
  logic [PartIdxW-1:0] res_idx_q, res_idx_d;
  logic [MaskW-1:0]    res_mask_q, res_mask_d;

  // Output register.
  logic                out_vld_q, out_vld_d;
  logic                out_succ_q;
  logic [PartIdxW-1:0] out_idx_q;
  logic [MaskW-1:0]    out_mask_q;

  logic                in_fire;
  logic                rd_en;
  logic [PartIdxW-1:0] rd_addr;
  logic [JobW-1:0]     rd_tag;
  tag_wr_t             tag_wr;
  logic [PartIdxW-1:0] size_sel;
  logic [SizeW-1:0]    cur_size;
  logic [SizeW-1:0]    cur_left;
  logic                scan_last;
  logic                out_free;

  assign in_fire  = in_if.valid & in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_free = ~out_vld_q | out_if.ready;

  // Configuration writes; indexes past the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxParts; i++) begin
        size_q[i] <= '0;
      end
    end else if (cfg_if.valid && (cfg_if.index < CfgIdxW'(MaxParts))) begin
      size_q[cfg_if.index] <= cfg_if.data;
    end
  end

  bfpa_tag_store #(
    .NumPartitions(NumPartitions)
  ) u_tag_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_tag_o (rd_tag),
    .wr_i     (tag_wr)
  );

  assign size_sel  = PartIdxW'(pidx_q);
  assign cur_size  = size_q[size_sel];
  assign cur_left  = cur_size - req_q;
  assign scan_last = pv_q && (pidx_q == IdxW'(NumPartitions - 1));

  // Sequencer: read one tag per cycle, evaluate it in the next cycle.
  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    pv_d       = 1'b0;
    pidx_d     = pidx_q;
    found_d    = found_q;
    best_d     = best_q;
    left_d     = left_q;
    mask_d     = mask_q;
    res_succ_d = res_succ_q;
    res_idx_d  = res_idx_q;
    res_mask_d = res_mask_q;
    rd_en      = 1'b0;
    rd_addr    = PartIdxW'(rd_cnt_q[IdxW-1:0]);
    tag_wr     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rd_cnt_d   = '0;
          found_d    = 1'b0;
          best_d     = '0;
          left_d     = '0;
          mask_d     = '0;
          res_succ_d = 1'b0;
          res_idx_d  = '0;
          res_mask_d = '0;
          // Job zero is the free marker and is refused without a scan.
          state_d    = (in_if.job_id == '0) ? ST_DONE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next read.
        if (rd_cnt_q < CntW'(NumPartitions)) begin
          rd_en    = 1'b1;
          pv_d     = 1'b1;
          pidx_d   = rd_cnt_q[IdxW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end

        // Evaluate the entry read in the previous cycle.
        if (pv_q) begin
          if (mode_q == MODE_ALLOC) begin
            if ((rd_tag == '0) && (cur_size >= req_q) &&
                (!found_q || (cur_left < left_q))) begin
              found_d = 1'b1;
              best_d  = pidx_q;
              left_d  = cur_left;
            end
          end else if (rd_tag == job_q) begin
            tag_wr.en        = 1'b1;
            tag_wr.addr      = size_sel;
            tag_wr.data      = '0;
            mask_d[size_sel] = 1'b1;
          end
        end

        // After the last entry: claim the winner and form the result.
        if (scan_last) begin
          if (mode_q == MODE_ALLOC) begin
            res_succ_d = found_d;
            res_idx_d  = found_d ? PartIdxW'(best_d) : '0;
            res_mask_d = '0;
            if (found_d) begin
              tag_wr.en   = 1'b1;
              tag_wr.addr = PartIdxW'(best_d);
              tag_wr.data = job_q;
            end
          end else begin
            res_succ_d = 1'b1;
            res_idx_d  = '0;
            res_mask_d = mask_d;
          end
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid follows the result hand-off and the sink's acceptance.
  always_comb begin
    out_vld_d = out_vld_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && out_if.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      pv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      pv_q      <= pv_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= in_if.mode;
      job_q  <= in_if.job_id;
      req_q  <= in_if.request_size;
    end
    pidx_q     <= pidx_d;
    found_q    <= found_d;
    best_q     <= best_d;
    left_q     <= left_d;
    mask_q     <= mask_d;
    res_succ_q <= res_succ_d;
    res_idx_q  <= res_idx_d;
    res_mask_q <= res_mask_d;
    if ((state_q == ST_DONE) && out_free) begin
      out_succ_q <= res_succ_q;
      out_idx_q  <= res_idx_q;
      out_mask_q <= res_mask_q;
    end
  end

  assign out_if.valid           = out_vld_q;
  assign out_if.success         = out_succ_q;
  assign out_if.partition_index = out_idx_q;
  assign out_if.freed_mask      = out_mask_q;

endmodule : best_fit_partition_allocator_core

`default_nettype wire

// ===== hw/rtl/bfpa_tag_store.sv =====
// Owner tag store: a synchronous memory with one read and one write port.
// Per-entry valid bits make unwritten entries read as free (tag zero).
// Depends on bfpa_pkg.
`default_nettype none

module bfpa_tag_store
  import bfpa_pkg::*;
#(
  parameter int unsigned NumPartitions = NumPartitionsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [PartIdxW-1:0] rd_addr_i,
  output      logic [JobW-1:0]     rd_tag_o,
  input  wire tag_wr_t             wr_i
);

  localparam int unsigned IdxW = (NumPartitions > 1) ? $clog2(NumPartitions) : 1;

  logic [JobW-1:0]          mem_q [NumPartitions];
  logic [NumPartitions-1:0] vld_q;
  logic [JobW-1:0]          rd_data_q;
  logic                     rd_vld_q;
  logic [IdxW-1:0]          rd_idx;
  logic [IdxW-1:0]          wr_idx;

  assign rd_idx = rd_addr_i[IdxW-1:0];
  assign wr_idx = wr_i.addr[IdxW-1:0];

  // Memory array and its registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  // Valid bits: an entry holds meaningful data once it has been written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx];
      end
    end
  end

  // An entry never written reads as a free partition.
  assign rd_tag_o = rd_vld_q ? rd_data_q : '0;

endmodule : bfpa_tag_store

`default_nettype wire
